### hw/rtl/grs_pkg.sv
// Shared types and codes for the graph route reachability block.
// No dependencies; imported by the top level, the checker and the testbench.
`default_nettype none

package grs_pkg;

  // Item action codes
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EDGE  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_POP   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/grs_pick.sv
// Neighbour picker: lowest open neighbour of a row, given the visited marks.
// Depends on nothing; instantiated once by graph_route_reachability_top.
`default_nettype none

module grs_pick #(
  parameter int N  = 32,
  parameter int IW = 5
) (
  input  wire logic [N-1:0]  row,
  input  wire logic [N-1:0]  mask,
  output logic               any,
  output logic [N-1:0]       onehot,
  output logic [IW-1:0]      index
);

  logic [N-1:0] open_bits;

  assign open_bits = row & ~mask;
  assign any       = |open_bits;
  // isolate the lowest set bit with one wide add
  assign onehot    = open_bits & (~open_bits + N'(1));

  // encode the isolated bit
  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) index = index | IW'(i);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/graph_route_reachability_top.sv
// Top level of the graph route reachability block: edge store, search
// sequencer, node stack and result register. Depends on grs_pkg and grs_pick.
`default_nettype none
//
//  Channel   Ports                                             Direction
//  --------  ------------------------------------------------  ---------
//  input     in_valid, in_stall, in_action, in_origin_city,    into block
//            in_target_city
//  result    out_valid, out_stall, out_route_found             out of block
//
//  A clear transfer finishes without making the block busy; an edge add
//  reads the row, then writes the row back. A query pushes and pops nodes,
//  paced by the single edge memory read port and the shared neighbour
//  picker. Reset (synchronous, rst_n low) empties the graph through per-row
//  valid bits, so no clearing pass is needed. in_stall stays high while an
//  item is at work; a finished query result waits in the output register
//  while the next item is accepted, and a second result holds in its final
//  state until the first has been taken.
//
module graph_route_reachability_top
  import grs_pkg::*;
#(
  parameter int MAX_CITIES = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_action,
  input  wire logic [4:0] in_origin_city,
  input  wire logic [4:0] in_target_city,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_route_found
);

  localparam int NW = $clog2(MAX_CITIES);
  localparam int FW = $clog2(MAX_CITIES + 1);

  // Storage: edge rows and node stack
  logic [MAX_CITIES-1:0] adj_mem [MAX_CITIES];
  logic [NW-1:0]         stk_mem [MAX_CITIES];

  // Registers
  state_t                state_r,     state_nxt;
  logic [MAX_CITIES-1:0] row_vld_r,   row_vld_nxt;
  logic [MAX_CITIES-1:0] visited_r,   visited_nxt;
  logic [FW-1:0]         fill_r,      fill_nxt;
  logic [NW-1:0]         top_r,       top_nxt;
  logic [NW-1:0]         org_r,       org_nxt;
  logic [NW-1:0]         tgt_r,       tgt_nxt;
  logic                  found_r,     found_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [MAX_CITIES-1:0] row_q_r;
  logic                  row_vq_r;
  logic [NW-1:0]         stk_q_r;

  // Memory port controls
  logic                  row_re, row_we;
  logic [NW-1:0]         row_ra, row_wa;
  logic [MAX_CITIES-1:0] row_wd;
  logic                  stk_re, stk_we;
  logic [NW-1:0]         stk_ra, stk_wa, stk_wd;

  // Input decode
  logic                  in_xfer;
  logic [6:0]            org_ext, tgt_ext;
  logic                  org_ok, tgt_ok;
  logic [NW-1:0]         org_idx, tgt_idx;
  logic [FW-1:0]         fill_m2;
  logic [MAX_CITIES-1:0] row_cur;

  // Picker outputs
  logic                  pick_any;
  logic [MAX_CITIES-1:0] pick_onehot;
  logic [NW-1:0]         pick_idx;

  assign in_xfer = in_valid && !in_stall;
  assign org_ext = {2'b00, in_origin_city};
  assign tgt_ext = {2'b00, in_target_city};
  assign org_ok  = org_ext < 7'(MAX_CITIES);
  assign tgt_ok  = tgt_ext < 7'(MAX_CITIES);
  assign org_idx = org_ext[NW-1:0];
  assign tgt_idx = tgt_ext[NW-1:0];
  assign fill_m2 = fill_r - FW'(2);

  // A row never written since the last clear reads as empty
  assign row_cur = row_vq_r ? row_q_r : '0;

  grs_pick #(
    .N  (MAX_CITIES),
    .IW (NW)
  ) u_pick (
    .row    (row_cur),
    .mask   (visited_r),
    .any    (pick_any),
    .onehot (pick_onehot),
    .index  (pick_idx)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    row_vld_nxt   = row_vld_r;
    visited_nxt   = visited_r;
    fill_nxt      = fill_r;
    top_nxt       = top_r;
    org_nxt       = org_r;
    tgt_nxt       = tgt_r;
    found_nxt     = found_r;
    // drop the held result once it is taken
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    row_re        = 1'b0;
    row_ra        = top_r;
    row_we        = 1'b0;
    row_wa        = org_r;
    row_wd        = row_cur | (MAX_CITIES'(1) << tgt_r);
    stk_re        = 1'b0;
    stk_ra        = fill_m2[NW-1:0];
    stk_we        = 1'b0;
    stk_wa        = fill_r[NW-1:0];
    stk_wd        = pick_idx;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (action_t'(in_action))
            ACT_CLEAR: begin
              row_vld_nxt = '0;
            end
            ACT_EDGE: begin
              // out-of-range nodes: ignore the edge
              if (org_ok && tgt_ok) begin
                row_re    = 1'b1;
                row_ra    = org_idx;
                org_nxt   = org_idx;
                tgt_nxt   = tgt_idx;
                state_nxt = ST_EDGE;
              end
            end
            ACT_QUERY: begin
              if (org_ok && tgt_ok) begin
                // push the origin as the stack base
                visited_nxt = MAX_CITIES'(1) << org_idx;
                stk_we      = 1'b1;
                stk_wa      = '0;
                stk_wd      = org_idx;
                fill_nxt    = FW'(1);
                top_nxt     = org_idx;
                tgt_nxt     = tgt_idx;
                state_nxt   = ST_CHECK;
              end else begin
                found_nxt = 1'b0;
                state_nxt = ST_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      ST_EDGE: begin
        row_we              = 1'b1;
        row_vld_nxt[org_r]  = 1'b1;
        state_nxt           = ST_IDLE;
      end

      ST_CHECK: begin
        if (top_r == tgt_r) begin
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          row_re    = 1'b1;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (pick_any) begin
          visited_nxt = visited_r | pick_onehot;
          // a full stack keeps its top and only marks the neighbour
          if (fill_r < FW'(MAX_CITIES)) begin
            stk_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
            top_nxt  = pick_idx;
          end
          state_nxt = ST_CHECK;
        end else begin
          fill_nxt = fill_r - FW'(1);
          if (fill_r == FW'(1)) begin
            found_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            stk_re    = 1'b1;
            state_nxt = ST_POP;
          end
        end
      end

      ST_POP: begin
        top_nxt   = stk_q_r;
        state_nxt = ST_CHECK;
      end

      ST_DONE: begin
        // hold here until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_vld_r   <= '0;
      visited_r   <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      visited_r   <= visited_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    org_r       <= org_nxt;
    tgt_r       <= tgt_nxt;
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
  end

  // Edge memory: one read, one write port
  always_ff @(posedge clk) begin
    if (row_we) adj_mem[row_wa] <= row_wd;
    if (row_re) begin
      row_q_r  <= adj_mem[row_ra];
      row_vq_r <= row_vld_r[row_ra];
    end
  end

  // Node stack memory
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_q_r <= stk_mem[stk_ra];
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_route_found = out_found_r;

endmodule

`default_nettype wire

### hw/rtl/grs_check.sv
// Port-level checker for graph_route_reachability_top, bound to it below.
// Depends on grs_pkg for the action codes.
`default_nettype none

module grs_check
  import grs_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_action,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_route_found
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_route_found))
    else $error("stalled result changed");

  // Clear and unused actions finish in the cycle they are taken
  a_clear_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_action == ACT_CLEAR || in_action == ACT_NONE) |=> !in_stall)
    else $error("clear or unused action left the block busy");

  // A query always keeps the block busy afterwards
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_QUERY |=> in_stall)
    else $error("query accepted without a busy period");

  // A new result follows only a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work");

endmodule

bind graph_route_reachability_top grs_check u_grs_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_route_found (out_route_found)
);

`default_nettype wire

### tb/tb_graph_route_reachability_top.sv
// Self-checking testbench for graph_route_reachability_top: directed and random
// edge, clear and route query transfers, with every answer predicted locally.
// Depends on grs_pkg and the RTL of the block; reads no files.
`default_nettype none

module tb_graph_route_reachability_top;
  import grs_pkg::*;

  localparam int NODES       = 32;
  localparam int ITEM_GOAL   = 1550;
  localparam int CALM_TAIL   = 150;  // items left when idling stops
  localparam int DRAIN_WAIT  = 200;  // settling wait once every answer is back
  localparam int HALF_PERIOD = 5;

  typedef struct {
    action_t    act;
    logic [4:0] src;
    logic [4:0] dst;
  } route_item_t;

  typedef struct {
    logic [4:0] src;
    logic [4:0] dst;
    bit         found;
  } route_answer_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = ACT_CLEAR;
  logic [4:0] in_origin_city = '0;
  logic [4:0] in_target_city = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_route_found;

  // Stimulus waiting to be driven, and answers waiting to come out
  route_item_t   pending[$];
  route_answer_t expected_route[$];

  // Local copy of the graph
  logic [NODES-1:0] edge_rows [NODES];

  int  mismatch_count = 0;
  int  item_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  in_taken = 1'b0;
  bit  calm = 1'b0;
  bit  idling = 1'b1;
  route_item_t   next_item;
  route_answer_t head_answer;

  graph_route_reachability_top #(.MAX_CITIES(NODES)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_origin_city (in_origin_city),
    .in_target_city (in_target_city),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_route_found(out_route_found)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Depth-first search over the local graph, lowest neighbour first.
  function automatic bit route_exists(input logic [4:0] src, input logic [4:0] dst);
    logic [NODES-1:0] seen;
    logic [NODES-1:0] open;
    logic [4:0]       trail [NODES];
    logic [4:0]       top;
    int               depth;
    int               nxt;
    bit               found;
    seen = '0;
    trail[0] = src;
    depth = 1;
    seen[src] = 1'b1;
    found = 1'b0;
    while (depth > 0 && !found) begin
      top = trail[depth-1];
      if (top == dst) begin
        found = 1'b1;
      end else begin
        open = edge_rows[top] & ~seen;
        if (open != '0) begin
          nxt = 0;
          while (!open[nxt]) nxt++;
          seen[nxt] = 1'b1;
          if (depth < NODES) begin
            trail[depth] = nxt[4:0];
            depth++;
          end
        end else begin
          depth--;
        end
      end
    end
    return found;
  endfunction

  task automatic queue_item(input action_t act, input int src, input int dst);
    route_item_t it;
    it.act = act;
    it.src = src[4:0];
    it.dst = dst[4:0];
    pending.insert(pending.size(), it);
    if (act != ACT_NONE) item_count++;
  endtask

  // Driver: present a new transfer at the falling edge once the last one has
  // gone, with random gaps while idling is on and none near the end.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          next_item = pending.pop_front();
          in_action      <= next_item.act;
          in_origin_city <= next_item.src;
          in_target_city <= next_item.dst;
          in_valid       <= 1'b1;
          if (idling && !calm && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts while idling is on, none near the end.
  always @(negedge clk) begin
    if (rst_n) begin
      if (calm) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: at each rising edge, update the local graph for an accepted input
  // transfer and check an accepted result against the oldest predicted answer.
  always @(posedge clk) begin
    calm = pending.size() < CALM_TAIL;
    // flip between idling and quiet stretches now and then
    if ($urandom_range(0, 299) == 0) idling = !idling;
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_route.size() == 0) begin
          $display("%0t: unexpected result, expected none, got route_found=%0b",
                   $time, out_route_found);
          mismatch_count++;
        end else begin
          head_answer = expected_route.pop_front();
          if (out_route_found !== head_answer.found) begin
            $display("%0t: route %0d->%0d: expected route_found=%0b, got %0b",
                     $time, head_answer.src, head_answer.dst, head_answer.found,
                     out_route_found);
            mismatch_count++;
          end
        end
      end
      if (in_taken) begin
        case (action_t'(in_action))
          ACT_CLEAR: begin
            for (int r = 0; r < NODES; r++) edge_rows[r] = '0;
          end
          ACT_EDGE: edge_rows[in_origin_city][in_target_city] = 1'b1;
          ACT_QUERY: begin
            head_answer.src   = in_origin_city;
            head_answer.dst   = in_target_city;
            head_answer.found = route_exists(in_origin_city, in_target_city);
            expected_route.insert(expected_route.size(), head_answer);
          end
          default: ;
        endcase
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int perm [NODES];
    int span, base, n_edges, n_queries, len, j, tmp, kind;
    for (int r = 0; r < NODES; r++) edge_rows[r] = '0;

    // Directed part: identities on an empty graph, self loops, extremes,
    // the unused action, cycles and two clears.
    queue_item(ACT_QUERY, 0, 0);
    queue_item(ACT_QUERY, 31, 31);
    queue_item(ACT_QUERY, 0, 31);
    queue_item(ACT_EDGE, 5, 5);
    queue_item(ACT_QUERY, 5, 6);
    queue_item(ACT_QUERY, 5, 5);
    queue_item(ACT_EDGE, 0, 31);
    queue_item(ACT_QUERY, 0, 31);
    queue_item(ACT_QUERY, 31, 0);
    queue_item(ACT_NONE, 31, 31);
    queue_item(ACT_NONE, 0, 0);
    queue_item(ACT_EDGE, 31, 16);
    queue_item(ACT_EDGE, 16, 0);
    queue_item(ACT_QUERY, 31, 0);
    queue_item(ACT_QUERY, 0, 16);
    queue_item(ACT_QUERY, 16, 5);
    queue_item(ACT_CLEAR, 0, 0);
    queue_item(ACT_QUERY, 0, 31);
    queue_item(ACT_QUERY, 16, 16);
    queue_item(ACT_EDGE, 10, 21);
    queue_item(ACT_EDGE, 21, 10);
    queue_item(ACT_QUERY, 10, 21);
    queue_item(ACT_QUERY, 21, 5);
    queue_item(ACT_CLEAR, 31, 31);

    // Random part, in episodes that mostly build a graph and then query it
    while (item_count < ITEM_GOAL) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // sparse graph on a window of nodes, wrapping round the index space
        if ($urandom_range(0, 4) != 0) queue_item(ACT_CLEAR, $urandom_range(0, 31),
                                                  $urandom_range(0, 31));
        span = $urandom_range(2, NODES);
        base = $urandom_range(0, NODES - 1);
        n_edges = $urandom_range(1, 2 * span);
        for (int e = 0; e < n_edges; e++)
          queue_item(ACT_EDGE, (base + $urandom_range(0, span - 1)) % NODES,
                     (base + $urandom_range(0, span - 1)) % NODES);
        n_queries = $urandom_range(2, 8);
        for (int q = 0; q < n_queries; q++) begin
          if ($urandom_range(0, 3) == 0)
            queue_item(ACT_QUERY, $urandom_range(0, 31), $urandom_range(0, 31));
          else
            queue_item(ACT_QUERY, (base + $urandom_range(0, span - 1)) % NODES,
                       (base + $urandom_range(0, span - 1)) % NODES);
        end
      end else if (kind <= 7) begin
        // long path through shuffled nodes, to drive the stack deep
        queue_item(ACT_CLEAR, 0, 0);
        for (int i = 0; i < NODES; i++) perm[i] = i;
        for (int i = NODES - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        len = ($urandom_range(0, 2) == 0) ? NODES : $urandom_range(2, NODES);
        for (int i = 0; i + 1 < len; i++) queue_item(ACT_EDGE, perm[i], perm[i + 1]);
        // dead-end branches and the odd back edge
        n_edges = $urandom_range(0, 6);
        for (int e = 0; e < n_edges; e++)
          queue_item(ACT_EDGE, perm[$urandom_range(0, len - 1)], $urandom_range(0, 31));
        queue_item(ACT_QUERY, perm[0], perm[len - 1]);
        queue_item(ACT_QUERY, perm[len - 1], perm[0]);
        n_queries = $urandom_range(1, 4);
        for (int q = 0; q < n_queries; q++)
          queue_item(ACT_QUERY, perm[$urandom_range(0, len - 1)],
                     perm[$urandom_range(0, NODES - 1)]);
      end else if (kind == 8) begin
        // noise: any action with any nodes, including the unused one
        n_queries = $urandom_range(1, 6);
        for (int q = 0; q < n_queries; q++)
          queue_item(action_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                     $urandom_range(0, 31));
      end else begin
        // grow the current graph and keep querying it
        n_queries = $urandom_range(3, 10);
        for (int q = 0; q < n_queries; q++) begin
          if ($urandom_range(0, 1) == 0)
            queue_item(ACT_EDGE, $urandom_range(0, 31), $urandom_range(0, 31));
          queue_item(ACT_QUERY, $urandom_range(0, 31), $urandom_range(0, 31));
        end
      end
    end

    // Hold reset low from the start, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every transfer sent, every answer back, then let the block settle
    while (pending.size() != 0 || in_valid || expected_route.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_route.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, expected_route.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: generous bound over the slowest legal run
  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hw/rtl/grs_pkg.sv
hw/rtl/grs_pick.sv
hw/rtl/graph_route_reachability_top.sv
hw/rtl/grs_check.sv
tb/tb_graph_route_reachability_top.sv
